// ===== rtl/chunked_transfer_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// chunked transfer decoder assertion macros
// shared check forms for the decoder's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_DECODER_DEFINES_SVH
`define CHUNKED_TRANSFER_DECODER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CDEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("chunked transfer decoder check failed");

// next-cycle implication, disabled while in reset
`define CDEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("chunked transfer decoder check failed");

`endif

// ===== rtl/cdec_pkg.sv =====
// ----------------------------------------------------------------------------
// cdec_pkg
// shared types, codes and helpers of the chunked transfer decoder
// ----------------------------------------------------------------------------
package cdec_pkg;

   // default widths
   localparam int SIZE_BITS_DEF  = 24;
   localparam int COUNT_BITS_DEF = 32;

   // parser phase codes
   localparam int PHASE_BITS = 4;
   localparam logic [PHASE_BITS-1:0] PH_FIRST   = 4'd0;
   localparam logic [PHASE_BITS-1:0] PH_SIZE    = 4'd1;
   localparam logic [PHASE_BITS-1:0] PH_EXT     = 4'd2;
   localparam logic [PHASE_BITS-1:0] PH_LF      = 4'd3;
   localparam logic [PHASE_BITS-1:0] PH_DATA    = 4'd4;
   localparam logic [PHASE_BITS-1:0] PH_AFTER   = 4'd5;
   localparam logic [PHASE_BITS-1:0] PH_AFTERCR = 4'd6;
   localparam logic [PHASE_BITS-1:0] PH_DONE    = 4'd7;
   localparam logic [PHASE_BITS-1:0] PH_ERR     = 4'd8;

   // status codes
   localparam logic [1:0] ST_BUSY  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // line characters
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;

   // one result item
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic [1:0]  status;
      logic [31:0] payload_count;
      logic        last;
   } rsp_type;

   // hex digit decode: {is digit, value}
   function automatic logic [4:0] hex_value(logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         d = c - 8'h30;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         d = c - 8'h57;
         return {1'b1, d[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         d = c - 8'h37;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

// ===== rtl/cdec_core.sv =====
// ----------------------------------------------------------------------------
// cdec_core
// per-message parser state and the combinational phase update for one byte
// ----------------------------------------------------------------------------
module cdec_core #(
   parameter int SIZE_BITS  = cdec_pkg::SIZE_BITS_DEF,
   parameter int COUNT_BITS = cdec_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_byte,
   input  logic              message_end,
   output cdec_pkg::rsp_type result
);
   import cdec_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  remaining_ff, remaining_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic [4:0]           hex;
   logic                 is_hex;
   logic [3:0]           digit;
   logic                 size_ovf;
   logic [SIZE_BITS-1:0] size_shifted;
   logic [SIZE_BITS-1:0] remaining_dec;
   logic                 pass_byte;
   logic [1:0]           status;

   // digit decode and size accumulate
   assign hex          = hex_value(in_byte);
   assign is_hex       = hex[4];
   assign digit        = hex[3:0];
   assign size_ovf     = (remaining_ff[SIZE_BITS-1 -: 4] != 4'd0);
   assign size_shifted = {remaining_ff[SIZE_BITS-5:0], digit};
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - SIZE_BITS'(1) : remaining_ff;

   // phase update for one byte
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      total_in     = total_ff;
      pass_byte    = 1'b0;
      case (phase_ff)
         PH_FIRST: begin
            if (is_hex) begin
               remaining_in = SIZE_BITS'(digit);
               phase_in     = PH_SIZE;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_SIZE: begin
            if (is_hex) begin
               if (size_ovf) begin
                  phase_in = PH_ERR;
               end else begin
                  remaining_in = size_shifted;
               end
            end else if (in_byte == CH_CR) begin
               phase_in = PH_LF;
            end else begin
               phase_in = PH_EXT;
            end
         end
         PH_EXT: begin
            if (in_byte == CH_CR) phase_in = PH_LF;
         end
         PH_LF: begin
            phase_in = (remaining_ff == '0) ? PH_DONE : PH_DATA;
         end
         PH_DATA: begin
            pass_byte    = 1'b1;
            total_in     = (total_ff != '1) ? total_ff + COUNT_BITS'(1) : total_ff;
            remaining_in = remaining_dec;
            if (remaining_dec == '0) phase_in = PH_AFTER;
         end
         PH_AFTER: begin
            if (in_byte == CH_CR) begin
               phase_in = PH_AFTERCR;
            end else if (is_hex) begin
               remaining_in = SIZE_BITS'(digit);
               phase_in     = PH_SIZE;
            end else begin
               phase_in = PH_ERR;
            end
         end
         PH_AFTERCR: begin
            phase_in = (in_byte == CH_LF) ? PH_FIRST : PH_ERR;
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_ERR;
         end
      endcase
   end

   // outcome, final on the last byte of a message
   always_comb begin
      if (message_end) begin
         status = (phase_in inside {PH_DONE, PH_AFTER, PH_FIRST}) ? ST_DONE : ST_ERROR;
      end else if (phase_in == PH_DONE) begin
         status = ST_DONE;
      end else if (phase_in == PH_ERR) begin
         status = ST_ERROR;
      end else begin
         status = ST_BUSY;
      end
   end

   // result item for this byte
   always_comb begin
      result.data_byte     = pass_byte ? in_byte : 8'h00;
      result.data_valid    = pass_byte;
      result.status        = status;
      result.payload_count = 32'(total_in);
      result.last          = message_end;
   end

   // state registers, back to start after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         remaining_ff <= '0;
         total_ff     <= '0;
      end else if (accept) begin
         if (message_end) begin
            phase_ff     <= PH_FIRST;
            remaining_ff <= '0;
            total_ff     <= '0;
         end else begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
            total_ff     <= total_in;
         end
      end
   end

endmodule

// ===== rtl/chunked_transfer_decoder.sv =====
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// the result of a taken byte goes to the output register, or to the skid register while rsp_ is stalled
// throughput: one byte per cycle while the skid is empty, set by the combinational phase update
// reset: synchronous; parser goes to expect first digit, output and skid empty
// ----------------------------------------------------------------------------
`include "chunked_transfer_decoder_defines.svh"

module chunked_transfer_decoder #(
   parameter int SIZE_BITS  = cdec_pkg::SIZE_BITS_DEF,
   parameter int COUNT_BITS = cdec_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_message_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_payload_count,
   output logic        rsp_last
);
   import cdec_pkg::*;

   rsp_type result;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    accept;
   logic    out_fire;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_fire  = out_valid_ff && rsp_ready;

   // parser
   cdec_core #(
      .SIZE_BITS  (SIZE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .message_end (req_message_end),
      .result      (result)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   // payload of output and skid
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_fire) out_ff <= skid_ff;
      end else if (accept) begin
         if (!out_valid_ff || out_fire) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_byte     = out_ff.data_byte;
   assign rsp_data_valid    = out_ff.data_valid;
   assign rsp_status        = out_ff.status;
   assign rsp_payload_count = out_ff.payload_count;
   assign rsp_last          = out_ff.last;

   // checks
   `CDEC_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CDEC_ASSERT_NEXT(a_stall_fills_skid, clock, reset, accept && out_valid_ff && !rsp_ready, skid_valid_ff)
   `CDEC_ASSERT_NOW(a_data_in_progress, clock, reset, rsp_valid && rsp_data_valid && !rsp_last, rsp_status == ST_BUSY)
   `CDEC_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_status != 2'd3)

endmodule
